// ===== design/scd_pkg.sv =====
// Shared types and constants for the step cadence detector.
// Used by every module in the design folder; depends on nothing else.
`timescale 1ns / 1ps

package scd_pkg;

    // Field widths
    localparam int AccelW   = 16;
    localparam int TimeW    = 48;
    localparam int SqW      = 31;
    localparam int MagW     = 32;
    localparam int TallyW   = 8;
    localparam int CadenceW = 16;
    localparam int SpeedW   = 18;

    // Configuration register widths
    localparam int ThrW     = 32;
    localparam int GapW     = 24;
    localparam int WinW     = 28;
    localparam int CpsW     = 8;
    localparam int SpsW     = 10;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_MAG_THR    = 3'd0,
        CFG_STEP_GAP   = 3'd1,
        CFG_WINDOW_LEN = 3'd2,
        CFG_CADENCE    = 3'd3,
        CFG_SPEED      = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [ThrW-1:0] MagThrReset    = 32'd355005890;
    localparam logic [GapW-1:0] StepGapReset   = 24'd300000;
    localparam logic [WinW-1:0] WindowLenReset = 28'd3000000;
    localparam logic [CpsW-1:0] CadenceReset   = 8'd20;
    localparam logic [SpsW-1:0] SpeedReset     = 10'd250;

    localparam logic [TallyW-1:0] TallyMax = 8'hFF;

    // One accelerometer sample
    typedef struct packed {
        logic signed [AccelW-1:0] x;
        logic signed [AccelW-1:0] y;
        logic signed [AccelW-1:0] z;
        logic [TimeW-1:0]         time_us;
    } sample_t;

    // Magnitude test result travelling to the step tracker
    typedef struct packed {
        logic             hit;
        logic [TimeW-1:0] time_us;
    } mag_t;

    // Step and window decision travelling to the scaler
    typedef struct packed {
        logic              step_seen;
        logic              window_done;
        logic [TallyW-1:0] window_steps;
    } decision_t;

    // Tracker state made visible to the top level
    typedef struct packed {
        logic [TallyW-1:0] tally;
        logic              started;
    } tracker_status_t;

endpackage

// ===== design/step_cadence_detector.sv =====
// Step cadence detector: top level with input register and configuration registers.
// Depends on scd_pkg, scd_magnitude, scd_tracker and scd_scaler.
//
// Usage
//   Samples enter on the s_axis channel, one word per sample, and every
//   sample gives exactly one result word on the m_axis channel, in order.
//   The result carries the step flag and, when the cadence window closed on
//   that sample, the window's step count, cadence and speed.
//   Registers are written through cfg_we / cfg_index / cfg_data while no
//   sample is in flight; writes to an unknown index are ignored.
// Timing
//   Five register stages: input, square, magnitude, decision and result.
//   One sample per cycle is taken in steady state while m_axis is not stalled;
//   the step and window state is updated in a single stage, so consecutive
//   samples need no gap.
// Reset and stalls
//   Reset empties the pipeline, clears the tally and timestamps, marks the
//   window as not yet opened and loads the default register values.
//   When m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready falls in the same cycle.
`timescale 1ns / 1ps

module step_cadence_detector
(
    input  logic                              clk,
    input  logic                              rst_n,
    // x[15:0], y[31:16], z[47:32], time_us[95:48]
    input  logic [95:0]                       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // step_seen[0], window_steps[8:1], cadence_rate[24:9], speed_mm_s[42:25], zero fill
    output logic [47:0]                       m_axis_tdata,
    // window_done[0]
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [scd_pkg::CfgIdxW-1:0]       cfg_index,
    input  logic [scd_pkg::CfgDataW-1:0]      cfg_data
);

    logic                          en;
    logic                          in_valid_reg;
    scd_pkg::sample_t              sample_reg;
    scd_pkg::sample_t              sample_next;

    logic [scd_pkg::ThrW-1:0]      mag_thr_reg;
    logic [scd_pkg::GapW-1:0]      step_gap_reg;
    logic [scd_pkg::WinW-1:0]      window_len_reg;
    logic [scd_pkg::CpsW-1:0]      cadence_reg;
    logic [scd_pkg::SpsW-1:0]      speed_reg;

    logic                          mag_valid;
    scd_pkg::mag_t                 mag;
    logic                          dec_valid;
    scd_pkg::decision_t            decision;
    scd_pkg::tracker_status_t      status;

    logic                          step_seen;
    logic                          window_done;
    logic [scd_pkg::TallyW-1:0]    window_steps;
    logic [scd_pkg::CadenceW-1:0]  cadence_rate;
    logic [scd_pkg::SpeedW-1:0]    speed_mm_s;

    // The pipeline moves whenever the result register is free or being taken
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Unpack the incoming word
    always_comb
    begin
        sample_next.x       = s_axis_tdata[15:0];
        sample_next.y       = s_axis_tdata[31:16];
        sample_next.z       = s_axis_tdata[47:32];
        sample_next.time_us = s_axis_tdata[95:48];
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= sample_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_thr_reg    <= scd_pkg::MagThrReset;
            step_gap_reg   <= scd_pkg::StepGapReset;
            window_len_reg <= scd_pkg::WindowLenReset;
            cadence_reg    <= scd_pkg::CadenceReset;
            speed_reg      <= scd_pkg::SpeedReset;
        end
        else if (cfg_we)
        begin
            case (scd_pkg::cfg_idx_t'(cfg_index))
                scd_pkg::CFG_MAG_THR:    mag_thr_reg    <= cfg_data[scd_pkg::ThrW-1:0];
                scd_pkg::CFG_STEP_GAP:   step_gap_reg   <= cfg_data[scd_pkg::GapW-1:0];
                scd_pkg::CFG_WINDOW_LEN: window_len_reg <= cfg_data[scd_pkg::WinW-1:0];
                scd_pkg::CFG_CADENCE:    cadence_reg    <= cfg_data[scd_pkg::CpsW-1:0];
                scd_pkg::CFG_SPEED:      speed_reg      <= cfg_data[scd_pkg::SpsW-1:0];
                default:                 ;
            endcase
        end
    end

    scd_magnitude u_magnitude
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .sample    (sample_reg),
        .mag_thr   (mag_thr_reg),
        .out_valid (mag_valid),
        .mag       (mag)
    );

    scd_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (mag_valid),
        .mag        (mag),
        .step_gap   (step_gap_reg),
        .window_len (window_len_reg),
        .out_valid  (dec_valid),
        .decision   (decision),
        .status     (status)
    );

    scd_scaler u_scaler
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (dec_valid),
        .decision         (decision),
        .cadence_per_step (cadence_reg),
        .speed_per_step   (speed_reg),
        .out_valid        (m_axis_tvalid),
        .step_seen        (step_seen),
        .window_done      (window_done),
        .window_steps     (window_steps),
        .cadence_rate     (cadence_rate),
        .speed_mm_s       (speed_mm_s)
    );

    // Pack the result word
    assign m_axis_tdata = {5'd0, speed_mm_s, cadence_rate, window_steps, step_seen};
    assign m_axis_tuser = window_done;

    // An open window reports no counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[42:1] == '0))
        else $error("window counts present without a window close");

    // The tally only grows by one step at a time or is cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.tally != $past(status.tally)) |->
        ((status.tally == '0) || (status.tally == $past(status.tally) + 1'b1)))
        else $error("step tally jumped");

    // Once opened, the cadence window stays open until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(status.started) |-> status.started)
        else $error("cadence window lost its start");

endmodule

// ===== design/scd_magnitude.sv =====
// Squared magnitude of a sample and its compare against the threshold.
// Two register stages; depends on scd_pkg.
`timescale 1ns / 1ps

module scd_magnitude
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  scd_pkg::sample_t              sample,
    input  logic [scd_pkg::ThrW-1:0]      mag_thr,
    output logic                          out_valid,
    output scd_pkg::mag_t                 mag
);

    logic                         sq_valid_reg;
    logic [scd_pkg::SqW-1:0]      sq_x_reg;
    logic [scd_pkg::SqW-1:0]      sq_y_reg;
    logic [scd_pkg::SqW-1:0]      sq_z_reg;
    logic [scd_pkg::TimeW-1:0]    sq_time_reg;
    logic [scd_pkg::SqW-1:0]      sq_x_next;
    logic [scd_pkg::SqW-1:0]      sq_y_next;
    logic [scd_pkg::SqW-1:0]      sq_z_next;
    logic signed [2*scd_pkg::AccelW-1:0] prod_x;
    logic signed [2*scd_pkg::AccelW-1:0] prod_y;
    logic signed [2*scd_pkg::AccelW-1:0] prod_z;
    logic [scd_pkg::MagW-1:0]     mag_sq;
    logic                         mag_valid_reg;
    scd_pkg::mag_t                mag_reg;
    scd_pkg::mag_t                mag_next;

    // Squares are never negative and stay below 2^31
    always_comb
    begin
        prod_x    = sample.x * sample.x;
        prod_y    = sample.y * sample.y;
        prod_z    = sample.z * sample.z;
        sq_x_next = prod_x[scd_pkg::SqW-1:0];
        sq_y_next = prod_y[scd_pkg::SqW-1:0];
        sq_z_next = prod_z[scd_pkg::SqW-1:0];
    end

    // The sum of three squares fits in 32 bits
    always_comb
    begin
        mag_sq = scd_pkg::MagW'(sq_x_reg) + scd_pkg::MagW'(sq_y_reg)
               + scd_pkg::MagW'(sq_z_reg);
        mag_next.hit     = mag_sq > mag_thr;
        mag_next.time_us = sq_time_reg;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            mag_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_valid_reg  <= in_valid;
            mag_valid_reg <= sq_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg    <= sq_x_next;
            sq_y_reg    <= sq_y_next;
            sq_z_reg    <= sq_z_next;
            sq_time_reg <= sample.time_us;
            mag_reg     <= mag_next;
        end
    end

    assign out_valid = mag_valid_reg;
    assign mag       = mag_reg;

endmodule

// ===== design/scd_tracker.sv =====
// Step detection, step tally and cadence window tracking.
// Holds the running state of the block; depends on scd_pkg.
`timescale 1ns / 1ps

module scd_tracker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  scd_pkg::mag_t                 mag,
    input  logic [scd_pkg::GapW-1:0]      step_gap,
    input  logic [scd_pkg::WinW-1:0]      window_len,
    output logic                          out_valid,
    output scd_pkg::decision_t            decision,
    output scd_pkg::tracker_status_t      status
);

    logic [scd_pkg::TallyW-1:0] tally_reg;
    logic [scd_pkg::TallyW-1:0] tally_next;
    logic [scd_pkg::TimeW-1:0]  last_step_reg;
    logic [scd_pkg::TimeW-1:0]  last_step_next;
    logic [scd_pkg::TimeW-1:0]  open_time_reg;
    logic [scd_pkg::TimeW-1:0]  open_time_next;
    logic                       started_reg;
    logic                       dec_valid_reg;
    scd_pkg::decision_t         dec_reg;
    scd_pkg::decision_t         dec_next;

    logic [scd_pkg::TimeW-1:0]  now;
    logic [scd_pkg::TimeW-1:0]  open_eff;
    logic [scd_pkg::TimeW-1:0]  since_step;
    logic [scd_pkg::TimeW-1:0]  since_open;
    logic [scd_pkg::TallyW-1:0] tally_inc;
    logic                       step;
    logic                       done;

    // Elapsed times are clamped at zero when the clock goes backwards
    always_comb
    begin
        now        = mag.time_us;
        open_eff   = started_reg ? open_time_reg : now;
        since_step = (now >= last_step_reg) ? (now - last_step_reg) : '0;
        since_open = (now >= open_eff) ? (now - open_eff) : '0;
        step       = mag.hit && (since_step > scd_pkg::TimeW'(step_gap));
        done       = since_open > scd_pkg::TimeW'(window_len);
        tally_inc  = (step && (tally_reg != scd_pkg::TallyMax))
                   ? tally_reg + 1'b1 : tally_reg;

        last_step_next = step ? now : last_step_reg;
        open_time_next = done ? now : open_eff;
        tally_next     = done ? '0 : tally_inc;

        dec_next.step_seen    = step;
        dec_next.window_done  = done;
        dec_next.window_steps = done ? tally_inc : '0;
    end

    // Running state advances once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg     <= '0;
            last_step_reg <= '0;
            open_time_reg <= '0;
            started_reg   <= 1'b0;
            dec_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dec_valid_reg <= in_valid;
            if (in_valid)
            begin
                tally_reg     <= tally_next;
                last_step_reg <= last_step_next;
                open_time_reg <= open_time_next;
                started_reg   <= 1'b1;
            end
        end
    end

    // Decision word for the scaler
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dec_reg <= dec_next;
        end
    end

    assign out_valid      = dec_valid_reg;
    assign decision       = dec_reg;
    assign status.tally   = tally_reg;
    assign status.started = started_reg;

endmodule

// ===== design/scd_scaler.sv =====
// Cadence and speed from the closed window's step count, and the result register.
// Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_scaler
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  scd_pkg::decision_t              decision,
    input  logic [scd_pkg::CpsW-1:0]        cadence_per_step,
    input  logic [scd_pkg::SpsW-1:0]        speed_per_step,
    output logic                            out_valid,
    output logic                            step_seen,
    output logic                            window_done,
    output logic [scd_pkg::TallyW-1:0]      window_steps,
    output logic [scd_pkg::CadenceW-1:0]    cadence_rate,
    output logic [scd_pkg::SpeedW-1:0]      speed_mm_s
);

    logic                             res_valid_reg;
    scd_pkg::decision_t               res_dec_reg;
    logic [scd_pkg::CadenceW-1:0]     cadence_reg;
    logic [scd_pkg::CadenceW-1:0]     cadence_next;
    logic [scd_pkg::SpeedW-1:0]       speed_reg;
    logic [scd_pkg::SpeedW-1:0]       speed_next;

    // Products fit their fields exactly
    always_comb
    begin
        cadence_next = scd_pkg::CadenceW'(decision.window_steps)
                     * scd_pkg::CadenceW'(cadence_per_step);
        speed_next   = scd_pkg::SpeedW'(decision.window_steps)
                     * scd_pkg::SpeedW'(speed_per_step);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_dec_reg <= decision;
            cadence_reg <= cadence_next;
            speed_reg   <= speed_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign step_seen    = res_dec_reg.step_seen;
    assign window_done  = res_dec_reg.window_done;
    assign window_steps = res_dec_reg.window_steps;
    assign cadence_rate = cadence_reg;
    assign speed_mm_s   = speed_reg;

endmodule

// ===== sim/step_cadence_detector_tb.sv =====
// Self-checking testbench for the step cadence detector: directed and random samples
// are checked word by word against a cycle-free predictor of step and window state.
// Depends on scd_pkg and step_cadence_detector from the design folder.
`timescale 1ns / 1ps

module step_cadence_detector_tb;

    // Register indexes past the end of the list; writes there are ignored
    localparam logic [scd_pkg::CfgIdxW-1:0] CfgSpareFirst = 3'd5;
    // Timestamp base used to reach the top bits of the time field
    localparam logic [scd_pkg::TimeW-1:0] HighTimeBase = 48'hFFFF_0000_0000;

    // One result word as the predictor sees it
    typedef struct packed {
        logic                         step_seen;
        logic                         window_done;
        logic [scd_pkg::TallyW-1:0]   window_steps;
        logic [scd_pkg::CadenceW-1:0] cadence_rate;
        logic [scd_pkg::SpeedW-1:0]   speed_mm_s;
    } report_t;

    // Predicts the step and window report for each accepted sample and checks
    // the block's result words against the oldest pending report.
    class cadence_checker;
        logic [scd_pkg::ThrW-1:0]   mag_thr;
        logic [scd_pkg::GapW-1:0]   step_gap;
        logic [scd_pkg::WinW-1:0]   window_len;
        logic [scd_pkg::CpsW-1:0]   cadence_per_step;
        logic [scd_pkg::SpsW-1:0]   speed_per_step;
        logic [scd_pkg::TallyW-1:0] tally;
        logic [scd_pkg::TimeW-1:0]  last_step_us;
        logic [scd_pkg::TimeW-1:0]  window_open_us;
        bit                         window_open;
        report_t                    expected_reports[$];
        int                         errors;

        function new();
            mag_thr          = scd_pkg::MagThrReset;
            step_gap         = scd_pkg::StepGapReset;
            window_len       = scd_pkg::WindowLenReset;
            cadence_per_step = scd_pkg::CadenceReset;
            speed_per_step   = scd_pkg::SpeedReset;
            tally            = '0;
            last_step_us     = '0;
            window_open_us   = '0;
            window_open      = 1'b0;
            errors           = 0;
        endfunction

        // Register writes keep only the low bits; unknown indexes do nothing.
        function void apply_register(logic [scd_pkg::CfgIdxW-1:0] idx,
                                     logic [scd_pkg::CfgDataW-1:0] val);
            case (idx)
                scd_pkg::CFG_MAG_THR:    mag_thr = val[scd_pkg::ThrW-1:0];
                scd_pkg::CFG_STEP_GAP:   step_gap = val[scd_pkg::GapW-1:0];
                scd_pkg::CFG_WINDOW_LEN: window_len = val[scd_pkg::WinW-1:0];
                scd_pkg::CFG_CADENCE:    cadence_per_step = val[scd_pkg::CpsW-1:0];
                scd_pkg::CFG_SPEED:      speed_per_step = val[scd_pkg::SpsW-1:0];
                default:                 ;
            endcase
        endfunction

        // A timestamp earlier than the reference counts as no time at all.
        function logic [scd_pkg::TimeW-1:0] elapsed_us(logic [scd_pkg::TimeW-1:0] now_us,
                                                       logic [scd_pkg::TimeW-1:0] then_us);
            return (now_us >= then_us) ? now_us - then_us : '0;
        endfunction

        function void note_sample(logic [95:0] word);
            logic signed [scd_pkg::AccelW-1:0] ax;
            logic signed [scd_pkg::AccelW-1:0] ay;
            logic signed [scd_pkg::AccelW-1:0] az;
            logic [scd_pkg::TimeW-1:0] now_us;
            longint energy;
            report_t r;
            {now_us, az, ay, ax} = word;
            energy = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
            r = '0;

            // Step test: squared magnitude over threshold and past the refractory gap.
            if (energy > longint'({1'b0, mag_thr}) &&
                elapsed_us(now_us, last_step_us) > step_gap)
            begin
                r.step_seen  = 1'b1;
                last_step_us = now_us;
                if (tally != scd_pkg::TallyMax)
                    tally = tally + 1'b1;
            end

            if (!window_open)
            begin
                window_open    = 1'b1;
                window_open_us = now_us;
            end

            // Window close reports the tally, including a step on this very sample.
            if (elapsed_us(now_us, window_open_us) > window_len)
            begin
                r.window_done  = 1'b1;
                r.window_steps = tally;
                r.cadence_rate = tally * cadence_per_step;
                r.speed_mm_s   = tally * speed_per_step;
                tally          = '0;
                window_open_us = now_us;
            end
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [scd_pkg::SpeedW-1:0] want,
                                    logic [scd_pkg::SpeedW-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [47:0] data, logic [0:0] user);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h/%h",
                         $time, data, user);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("step_seen", scd_pkg::SpeedW'(want.step_seen),
                          scd_pkg::SpeedW'(data[0]));
            compare_field("window_done", scd_pkg::SpeedW'(want.window_done),
                          scd_pkg::SpeedW'(user[0]));
            compare_field("window_steps", scd_pkg::SpeedW'(want.window_steps),
                          scd_pkg::SpeedW'(data[8:1]));
            compare_field("cadence_rate", scd_pkg::SpeedW'(want.cadence_rate),
                          scd_pkg::SpeedW'(data[24:9]));
            compare_field("speed_mm_s", want.speed_mm_s, data[42:25]);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic [95:0]                   s_axis_tdata = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [47:0]                   m_axis_tdata;
    logic [0:0]                    m_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [scd_pkg::CfgIdxW-1:0]   cfg_index = '0;
    logic [scd_pkg::CfgDataW-1:0]  cfg_data = '0;

    cadence_checker report_check = new();

    // Idling controls for the sender and the receiver
    int unsigned               tx_rate = 0;
    int unsigned               rx_rate = 0;
    int unsigned               rx_hold_cycles = 0;
    bit                        quiet = 1'b0;
    logic [scd_pkg::TimeW-1:0] clock_us = '0;

    step_cadence_detector dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result words are checked at the edge that accepts them.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            report_check.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Receiver: random stall bursts in changing regimes, plus one long hold on request.
    initial
    begin : rx_side
        int unsigned cycle;
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle % 100 == 0)
                rx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && rx_rate != 0 && $urandom_range(1, rx_rate) == 1)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one sample word, with an optional idle burst first, and note it once taken.
    task automatic send_sample(input logic signed [scd_pkg::AccelW-1:0] ax,
                               input logic signed [scd_pkg::AccelW-1:0] ay,
                               input logic signed [scd_pkg::AccelW-1:0] az,
                               input logic [scd_pkg::TimeW-1:0] t_us);
        logic [95:0] word;
        int unsigned gap;
        word = {t_us, az, ay, ax};
        gap  = 0;
        if (!quiet && tx_rate != 0 && $urandom_range(1, tx_rate) == 1)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        report_check.note_sample(word);
    endtask

    // Stop offering and wait until every pending report has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (report_check.pending() != 0);
    endtask

    task automatic write_register(input logic [scd_pkg::CfgIdxW-1:0] idx,
                                  input logic [scd_pkg::CfgDataW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        report_check.apply_register(idx, val);
    endtask

    // Load a full register set once idle; upper junk bits test truncation.
    task automatic load_settings(input logic [scd_pkg::ThrW-1:0] thr,
                                 input logic [scd_pkg::GapW-1:0] gap,
                                 input logic [scd_pkg::WinW-1:0] win,
                                 input logic [scd_pkg::CpsW-1:0] cps,
                                 input logic [scd_pkg::SpsW-1:0] sps);
        drain_results();
        write_register(scd_pkg::CFG_MAG_THR, thr);
        write_register(scd_pkg::CFG_STEP_GAP, {8'($urandom), gap});
        write_register(scd_pkg::CFG_WINDOW_LEN, {4'($urandom), win});
        write_register(scd_pkg::CFG_CADENCE, {24'($urandom), cps});
        write_register(scd_pkg::CFG_SPEED, {22'($urandom), sps});
        write_register(CfgSpareFirst + 3'($urandom_range(0, 2)), $urandom());
        cfg_we  <= 1'b0;
        tx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
    endtask

    // Random walk: strides of rest samples near 1 g mixed with hard strikes,
    // with the odd timestamp that runs backwards.
    task automatic walk_samples(input int count, input int unsigned dt_max);
        logic signed [scd_pkg::AccelW-1:0] ax;
        logic signed [scd_pkg::AccelW-1:0] ay;
        logic signed [scd_pkg::AccelW-1:0] az;
        logic [scd_pkg::TimeW-1:0] t_us;
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick     = $urandom_range(0, 99);
            clock_us = clock_us + $urandom_range(0, dt_max);
            t_us     = clock_us;
            if (pick < 45)
            begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
            end
            else
            begin
                ax = 16'($urandom_range(0, 6000) - 3000);
                ay = 16'($urandom_range(0, 6000) - 3000);
                az = 16'(16384 + $urandom_range(0, 4000) - 2000);
                if ($urandom_range(0, 1) == 1)
                    az = -az;
            end
            if (pick >= 96 && clock_us > 5000)
                t_us = clock_us - $urandom_range(1, 5000);
            send_sample(ax, ay, az, t_us);
        end
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_rate = 4;

        // Default registers: opening sample, magnitude extremes, gap and window edges.
        send_sample(16'sd0, 16'sd0, 16'sd0, 48'd0);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 48'd100000);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767, 48'd300000);
        send_sample(-16'sd32768, 16'sd0, 16'sd0, 48'd300001);
        send_sample(16'sd0, 16'sd0, -16'sd32768, 48'd300001);
        send_sample(16'sd20000, 16'sd0, 16'sd0, 48'd600001);
        send_sample(16'sd0, 16'sd20000, 16'sd0, 48'd600002);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 48'd700000);
        // Timestamp running backwards
        send_sample(16'sd0, 16'sd0, 16'sd32767, 48'd650000);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 48'd3000000);
        // Window closes on a sample that is itself a step
        send_sample(16'sd0, -16'sd25000, 16'sd0, 48'd3000001);
        send_sample(16'sd1, -16'sd1, 16'sd1, 48'd3000002);

        // Tiny threshold, zero gap and zero window, largest multipliers.
        load_settings(32'd100, 24'd0, 28'd0, 8'd255, 10'd1023);
        send_sample(16'sd10, 16'sd0, 16'sd0, 48'd3000010);
        send_sample(16'sd10, 16'sd0, 16'sd1, 48'd3000011);
        send_sample(16'sd10, 16'sd0, 16'sd1, 48'd3000011);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 48'd3000012);
        load_settings(32'd0, 24'd0, 28'd0, 8'd255, 10'd1023);
        send_sample(16'sd0, 16'sd0, 16'sd0, 48'd3000013);
        send_sample(16'sd0, 16'sd0, -16'sd1, 48'd3000014);
        clock_us = 48'd3000014;

        // Tally saturation: a step on every sample inside the longest window.
        load_settings(32'd0, 24'd0, 28'hFFF_FFFF, 8'd255, 10'd1023);
        for (int i = 0; i < 300; i++)
        begin
            clock_us = clock_us + 1;
            send_sample(16'($urandom) | 16'sd1, 16'($urandom), 16'($urandom), clock_us);
        end
        clock_us = clock_us + 48'd268435456;
        send_sample(16'sd0, 16'sd0, 16'sd32767, clock_us);

        // Threshold near its default, short gaps and windows; pause for a full drain midway.
        load_settings(32'($urandom_range(250000000, 450000000)), 24'($urandom_range(0, 2000)),
                      28'($urandom_range(1, 20000)), 8'($urandom), 10'($urandom));
        walk_samples(40, 1500);
        drain_results();
        walk_samples(40, 1500);

        // Largest threshold, gap and window: no new steps, one window close.
        load_settings(32'd3221225472, 24'hFF_FFFF, 28'hFFF_FFFF, 8'd0, 10'd0);
        walk_samples(25, 1000);
        clock_us = clock_us + 48'd268435456;
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768, clock_us);
        walk_samples(4, 1000);

        // Any threshold, window of one: long receiver hold while samples keep coming.
        load_settings(32'($urandom_range(0, 32'd3221225472)), 24'd0, 28'd1,
                      8'($urandom), 10'($urandom));
        rx_hold_cycles = 80;
        tx_rate        = 0;
        walk_samples(40, 3);
        tx_rate = 5;
        walk_samples(40, 3);

        // Timestamps high in the range.
        load_settings(scd_pkg::MagThrReset, 24'd500, 28'd10000, 8'($urandom), 10'($urandom));
        clock_us = HighTimeBase;
        walk_samples(80, 1000);

        load_settings(32'($urandom_range(300000000, 400000000)), 24'($urandom_range(0, 3000)),
                      28'($urandom_range(1, 30000)), 8'($urandom), 10'($urandom));
        walk_samples(100, 2000);

        // Closing stretch at default settings with no idling on either side.
        quiet = 1'b1;
        load_settings(scd_pkg::MagThrReset, scd_pkg::StepGapReset, scd_pkg::WindowLenReset,
                      scd_pkg::CadenceReset, scd_pkg::SpeedReset);
        walk_samples(80, 200000);

        drain_results();
        repeat (10) @(posedge clk);
        if (report_check.errors == 0 && report_check.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
